>>> src/mue_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mue_pkg: shared types and constants
// Widths of the shared multiplier and divider, fixed-point constants and the
// root table used by the power-of-two routine.
// ----------------------------------------------------------------------------
package mue_pkg;

  localparam int MUL_W     = 33;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int DIV_NUM_W = 48;
  localparam int DIV_DEN_W = 26;

  localparam logic [2:0] CFG_BANDS = 3'd0;

  localparam logic signed [17:0] LEVEL_FLOOR_Q8  = -18'sd51200;
  localparam logic signed [33:0] GAIN_MIN_Q8     = -34'sd15360;
  localparam logic signed [33:0] GAIN_MAX_Q8     = 34'sd12288;
  localparam logic [27:0]        DB_PER_LOG2_Q32 = 28'd101008907;
  localparam logic [21:0]        LOG2_PER_DB_Q16 = 22'd2786635;
  localparam logic [17:0]        TWO_LOG2E_Q16   = 18'd189098;
  localparam logic [14:0]        MIX_SCALE_Q16   = 15'd19661;
  localparam logic [23:0]        ENV_FLOOR_DIV   = 24'd8;
  localparam logic [16:0]        ONE_Q16         = 17'h10000;

  function automatic logic [16:0] root_q16(input logic [2:0] k);
    logic [16:0] r;
    case (k)
      3'd0:    r = 17'd92682;
      3'd1:    r = 17'd77936;
      3'd2:    r = 17'd71468;
      3'd3:    r = 17'd68438;
      3'd4:    r = 17'd66971;
      3'd5:    r = 17'd66250;
      3'd6:    r = 17'd65892;
      default: r = 17'd65714;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> src/multiband_upward_expander_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// multiband_upward_expander_unit: multiband upward expander
// One Q1.15 sample in, one saturated 24-bit sample out, summed over the
// active bands. A sequencer runs every band through one shared multiplier
// and one shared divider.
// ----------------------------------------------------------------------------
// A sample is taken only while the unit is idle. Each active band takes
// longer when the input exceeds the new envelope, since only then does the
// transient division run. The time is set by the log mantissa squaring
// (one squaring per bit on the shared multiplier) and the up to two
// divisions at one quotient bit per cycle. A finished sample waits in the
// output register while the next one is accepted. Band settings are
// bandK_settings: [15:0] attack, [31:16] release, [39:32] threshold dB,
// [51:40] slope Q1.10, [59:52] makeup dB.
module multiband_upward_expander_unit
  import mue_pkg::*;
#(
  parameter int NUM_BANDS = 4
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] audio_in,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [23:0]      audio_out,
  output logic                    clipped,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [63:0]        cfg_data
);

  localparam int BW = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
  localparam logic [2:0] NB = 3'(NUM_BANDS);

  typedef enum logic [4:0] {
    S_IDLE, S_ENV0, S_ENV1, S_ENV2, S_LOG0, S_LOGSQ, S_LOGNX, S_LOGL, S_LOGLV,
    S_GAIN0, S_GAIN1, S_GAIN2, S_GAIN3, S_PWK, S_PWM, S_PWS, S_TR0, S_TRW,
    S_TU, S_TU1, S_TU2, S_TH0, S_THW, S_MX0, S_MX1, S_MX2, S_MX3, S_MX4,
    S_MX5, S_ACC, S_FIN
  } state_t;

  state_t state;

  logic [2:0]  bands_in_use;
  logic [63:0] band_set [NUM_BANDS];
  logic [23:0] env_mem [NUM_BANDS];

  logic signed [15:0] x;
  logic [23:0]        a;
  logic [BW-1:0]      band;
  logic [2:0]         count;
  logic [15:0]        c_sel;
  logic signed [PROD_W-1:0] tmp;
  logic [23:0]        envr;
  logic [4:0]         lp;
  logic [15:0]        lm;
  logic [15:0]        frac;
  logic [3:0]         cnt;
  logic signed [17:0] lvl;
  logic signed [15:0] g;
  logic signed [23:0] pe;
  logic [17:0]        pm;
  logic [2:0]         pk;
  logic               pw_sel;
  logic [25:0]        gain;
  logic [16:0]        t;
  logic [25:0]        pbig;
  logic signed [24:0] th;
  logic [14:0]        mix;
  logic signed [25:0] y;
  logic signed [53:0] acc;

  // shared units
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;
  logic                     div_start;
  logic [DIV_NUM_W-1:0]     div_num;
  logic [DIV_DEN_W-1:0]     div_den;
  logic                     div_done;
  logic [DIV_NUM_W-1:0]     div_quo;

  mue_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(prod));

  mue_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  // band settings
  logic [63:0]        s;
  logic [15:0]        ca, cr, c_now;
  logic signed [15:0] thr, mk;
  logic signed [11:0] slope;
  logic [23:0]        env_cur;
  logic [2:0]         count_now;

  assign s       = band_set[band];
  assign ca      = s[15:0];
  assign cr      = s[31:16];
  assign thr     = $signed({s[39:32], 8'h00});
  assign slope   = $signed(s[51:40]);
  assign mk      = $signed({s[59:52], 8'h00});
  assign env_cur = env_mem[band];
  assign c_now   = (a > env_cur) ? ca : cr;
  assign count_now = (bands_in_use > NB) ? NB : bands_in_use;

  // derived values
  logic [4:0]          lp_now;
  logic [15:0]         lm_now;
  logic [16:0]         mm;
  logic signed [21:0]  lsig;
  logic signed [18:0]  diff;
  logic signed [31:0]  gsh;
  logic signed [33:0]  gsum;
  logic signed [23:0]  x23;
  logic [34:0]         pwr;
  logic signed [7:0]   pn;
  logic [47:0]         pw_full;
  logic [25:0]         pw;
  logic [31:0]         mixr;
  logic signed [PROD_W-1:0] ysum;
  logic signed [PROD_W-1:0] envsum;
  logic signed [37:0]  osum;

  always_comb begin
    lp_now = '0;
    for (int i = 0; i < 24; i++) begin
      if (env_cur[i]) lp_now = 5'(i);
    end
  end

  assign lm_now = (lp_now >= 5'd15) ? 16'(env_cur >> (lp_now - 5'd15))
                                    : 16'(env_cur << (5'd15 - lp_now));
  assign mm   = prod[31:15];
  assign lsig = $signed({6'(lp) - 6'd23, frac});
  assign diff = 19'(thr) - 19'(lvl);
  assign gsh  = (lvl < thr) ? prod[41:10] : 32'sd0;
  assign gsum = 34'(gsh) + 34'(mk);
  assign x23  = $signed({x, 8'h00});
  assign pwr  = prod[34:0] + 35'd32768;
  assign pn   = pe[23:16];
  assign mixr = prod[31:0] + 32'd32768;
  assign ysum = tmp + prod;
  assign envsum = ysum + PROD_W'(32768);
  assign osum = acc[53:16];

  always_comb begin
    pw_full = '0;
    if (!pn[7]) begin
      pw_full = {30'b0, pm} << ((pn > 8'sd30) ? 8'd30 : 8'(pn));
    end else if (pn >= -8'sd40) begin
      pw_full = {30'b0, pm} >> 8'(-pn);
    end
  end
  assign pw = pw_full[25:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_ENV0: begin
        mul_a = MUL_W'(c_now);
        mul_b = MUL_W'(env_cur);
      end
      S_ENV1: begin
        mul_a = MUL_W'(ONE_Q16 - 17'(c_sel));
        mul_b = MUL_W'(a);
      end
      S_LOGSQ: begin
        mul_a = MUL_W'(lm);
        mul_b = MUL_W'(lm);
      end
      S_LOGL: begin
        mul_a = MUL_W'(lsig);
        mul_b = MUL_W'(DB_PER_LOG2_Q32);
      end
      S_GAIN0: begin
        mul_a = MUL_W'(diff);
        mul_b = MUL_W'(slope);
      end
      S_GAIN2: begin
        mul_a = MUL_W'(g);
        mul_b = MUL_W'(LOG2_PER_DB_Q16);
      end
      S_PWK: begin
        mul_a = MUL_W'(pm);
        mul_b = MUL_W'(pe[4'd15 - {1'b0, pk}] ? root_q16(pk) : ONE_Q16);
      end
      S_TU: begin
        mul_a = MUL_W'(a);
        mul_b = MUL_W'(18'(ONE_Q16) + {t, 1'b0});
      end
      S_TU1: begin
        mul_a = MUL_W'(prod[41:23]);
        mul_b = MUL_W'(TWO_LOG2E_Q16);
      end
      S_MX0: begin
        mul_a = MUL_W'(t);
        mul_b = MUL_W'(MIX_SCALE_Q16);
      end
      S_MX2: begin
        mul_a = MUL_W'(x23);
        mul_b = MUL_W'(ONE_Q16 - 17'(mix));
      end
      S_MX3: begin
        mul_a = MUL_W'(th);
        mul_b = MUL_W'(mix);
      end
      S_MX5: begin
        mul_a = MUL_W'(y);
        mul_b = MUL_W'(gain);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    if (state == S_TR0 && a > envr) begin
      div_start = 1'b1;
      div_num   = DIV_NUM_W'({a - envr, 16'h0000});
      div_den   = DIV_DEN_W'((envr < ENV_FLOOR_DIV) ? ENV_FLOOR_DIV : envr);
    end else if (state == S_TH0) begin
      div_start = 1'b1;
      div_num   = {25'(pbig - 26'(ONE_Q16)), 23'b0};
      div_den   = pbig + 26'(ONE_Q16);
    end
  end

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bands_in_use <= '0;
      for (int i = 0; i < NUM_BANDS; i++) band_set[i] <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_BANDS) begin
        bands_in_use <= cfg_data[2:0];
      end else if (cfg_index <= NB) begin
        band_set[BW'(cfg_index - 3'd1)] <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_BANDS; i++) env_mem[i] <= '0;
    end else begin
      if (out_valid && !out_stall && state != S_FIN) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            x     <= audio_in;
            a     <= {(audio_in[15] ? 16'(-audio_in) : audio_in), 8'h00};
            band  <= '0;
            acc   <= '0;
            count <= count_now;
            state <= (count_now == 3'd0) ? S_FIN : S_ENV0;
          end
        end
        S_ENV0: begin
          c_sel <= c_now;
          state <= S_ENV1;
        end
        S_ENV1: begin
          tmp   <= prod;
          state <= S_ENV2;
        end
        S_ENV2: begin
          env_mem[band] <= envsum[39:16];
          state <= S_LOG0;
        end
        S_LOG0: begin
          envr  <= env_mem[band];
          lp    <= lp_now;
          lm    <= lm_now;
          frac  <= '0;
          cnt   <= '0;
          state <= S_LOGSQ;
          if (env_mem[band] == 24'd0) begin
            lvl   <= LEVEL_FLOOR_Q8;
            state <= S_GAIN0;
          end
        end
        S_LOGSQ: begin
          state <= S_LOGNX;
        end
        S_LOGNX: begin
          frac  <= {frac[14:0], mm[16]};
          lm    <= mm[16] ? mm[16:1] : mm[15:0];
          cnt   <= cnt + 1'b1;
          state <= (cnt == 4'd15) ? S_LOGL : S_LOGSQ;
        end
        S_LOGL: begin
          state <= S_LOGLV;
        end
        S_LOGLV: begin
          lvl   <= prod[49:32];
          state <= S_GAIN0;
        end
        S_GAIN0: begin
          state <= S_GAIN1;
        end
        S_GAIN1: begin
          if (gsum < GAIN_MIN_Q8)      g <= 16'(GAIN_MIN_Q8);
          else if (gsum > GAIN_MAX_Q8) g <= 16'(GAIN_MAX_Q8);
          else                         g <= 16'(gsum);
          state <= S_GAIN2;
        end
        S_GAIN2: begin
          state <= S_GAIN3;
        end
        S_GAIN3: begin
          pe     <= prod[39:16];
          pm     <= 18'(ONE_Q16);
          pk     <= '0;
          pw_sel <= 1'b0;
          state  <= S_PWK;
        end
        S_PWK: begin
          state <= S_PWM;
        end
        S_PWM: begin
          pm    <= pwr[33:16];
          pk    <= pk + 1'b1;
          state <= (pk == 3'd7) ? S_PWS : S_PWK;
        end
        S_PWS: begin
          if (!pw_sel) begin
            gain  <= pw;
            state <= S_TR0;
          end else begin
            pbig  <= pw;
            state <= S_TH0;
          end
        end
        S_TR0: begin
          if (a > envr) begin
            state <= S_TRW;
          end else begin
            t     <= '0;
            state <= S_TU;
          end
        end
        S_TRW: begin
          if (div_done) begin
            t     <= (div_quo > DIV_NUM_W'(ONE_Q16)) ? ONE_Q16 : div_quo[16:0];
            state <= S_TU;
          end
        end
        S_TU: begin
          state <= S_TU1;
        end
        S_TU1: begin
          state <= S_TU2;
        end
        S_TU2: begin
          pe     <= prod[39:16];
          pm     <= 18'(ONE_Q16);
          pk     <= '0;
          pw_sel <= 1'b1;
          state  <= S_PWK;
        end
        S_TH0: begin
          state <= S_THW;
        end
        S_THW: begin
          if (div_done) begin
            th    <= x[15] ? -$signed(25'(div_quo)) : $signed(25'(div_quo));
            state <= S_MX0;
          end
        end
        S_MX0: begin
          state <= S_MX1;
        end
        S_MX1: begin
          mix   <= mixr[30:16];
          state <= S_MX2;
        end
        S_MX2: begin
          state <= S_MX3;
        end
        S_MX3: begin
          tmp   <= prod;
          state <= S_MX4;
        end
        S_MX4: begin
          y     <= ysum[41:16];
          state <= S_MX5;
        end
        S_MX5: begin
          state <= S_ACC;
        end
        S_ACC: begin
          acc <= acc + 54'(prod);
          if (3'(band) + 3'd1 == count) begin
            state <= S_FIN;
          end else begin
            band  <= band + 1'b1;
            state <= S_ENV0;
          end
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            if (osum > 38'sd8388607) begin
              audio_out <= 24'sh7FFFFF;
              clipped   <= 1'b1;
            end else if (osum < -38'sd8388608) begin
              audio_out <= 24'sh800000;
              clipped   <= 1'b1;
            end else begin
              audio_out <= osum[23:0];
              clipped   <= 1'b0;
            end
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_env_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOGSQ) |-> (envr <= 24'h800000))
    else $error("envelope above full scale");

  a_clip_value: assert property (@(posedge clk) disable iff (rst)
    (out_valid && clipped) |-> (audio_out == 24'sh7FFFFF || audio_out == 24'sh800000))
    else $error("clip flag without saturated output");

  a_t_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_MX0) |-> (t <= ONE_Q16))
    else $error("transient strength above one");

  a_band_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACC) |-> (3'(band) < count))
    else $error("band index beyond active count");

endmodule
`default_nettype wire

>>> src/mue_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mue_mul: shared signed multiplier
// One signed product per cycle, registered at the output.
// ----------------------------------------------------------------------------
module mue_mul
  import mue_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic signed [MUL_W-1:0]  a,
  input  wire logic signed [MUL_W-1:0]  b,
  output logic signed [PROD_W-1:0]      p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule
`default_nettype wire

>>> src/mue_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mue_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle; done pulses when the
// quotient is ready.
// ----------------------------------------------------------------------------
module mue_div
  import mue_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [DIV_NUM_W-1:0]  num,
  input  wire logic [DIV_DEN_W-1:0]  den,
  output logic                       done,
  output logic [DIV_NUM_W-1:0]       quo
);

  localparam int CW = $clog2(DIV_NUM_W);

  logic                 busy;
  logic [CW-1:0]        cnt;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] d;
  logic [DIV_DEN_W:0]   r2;
  logic [DIV_DEN_W:0]   rdiff;
  logic                 ge;

  assign r2    = {rem, quo[DIV_NUM_W-1]};
  assign rdiff = r2 - {1'b0, d};
  assign ge    = r2 >= {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo  <= num;
        rem  <= '0;
        d    <= den;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem <= ge ? rdiff[DIV_DEN_W-1:0] : r2[DIV_DEN_W-1:0];
        quo <= {quo[DIV_NUM_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DIV_NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire
